[hdl/m4i_pkg.sv]
// m4i_pkg: shared types and constant tables for the 4x4 matrix inverse.
// Holds the 2x2 minor and adjugate term tables and the divider control type.
// No dependencies.
`default_nettype none

package m4i_pkg;

    localparam int CHUNK_W = 32;

    typedef struct packed {
        logic start;
        logic neg;
    } div_ctl_t;

    // Minor m: index 0..5 are rows 0/1 minors, 6..11 are rows 2/3 minors.
    // Returns {elem_a, elem_b} of product p; minor = prod(p=0) - prod(p=1).
    function automatic logic [7:0] minor_pair(input logic [3:0] m, input logic p);
        logic [7:0] r;
        r = 8'd0;
        case ({m, p})
            5'd0:  r = {4'd0, 4'd5};
            5'd1:  r = {4'd4, 4'd1};
            5'd2:  r = {4'd0, 4'd6};
            5'd3:  r = {4'd4, 4'd2};
            5'd4:  r = {4'd0, 4'd7};
            5'd5:  r = {4'd4, 4'd3};
            5'd6:  r = {4'd1, 4'd6};
            5'd7:  r = {4'd5, 4'd2};
            5'd8:  r = {4'd1, 4'd7};
            5'd9:  r = {4'd5, 4'd3};
            5'd10: r = {4'd2, 4'd7};
            5'd11: r = {4'd6, 4'd3};
            5'd12: r = {4'd8, 4'd13};
            5'd13: r = {4'd12, 4'd9};
            5'd14: r = {4'd8, 4'd14};
            5'd15: r = {4'd12, 4'd10};
            5'd16: r = {4'd8, 4'd15};
            5'd17: r = {4'd12, 4'd11};
            5'd18: r = {4'd9, 4'd14};
            5'd19: r = {4'd13, 4'd10};
            5'd20: r = {4'd9, 4'd15};
            5'd21: r = {4'd13, 4'd11};
            5'd22: r = {4'd10, 4'd15};
            5'd23: r = {4'd14, 4'd11};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Adjugate entry e, term t: {elem, minor, negate}.
    function automatic logic [8:0] adj_term(input logic [3:0] e, input logic [1:0] t);
        logic [8:0] r;
        r = 9'd0;
        case ({e, t})
            6'd0:  r = {4'd5, 4'd11, 1'b0};
            6'd1:  r = {4'd6, 4'd10, 1'b1};
            6'd2:  r = {4'd7, 4'd9, 1'b0};
            6'd4:  r = {4'd1, 4'd11, 1'b1};
            6'd5:  r = {4'd2, 4'd10, 1'b0};
            6'd6:  r = {4'd3, 4'd9, 1'b1};
            6'd8:  r = {4'd13, 4'd5, 1'b0};
            6'd9:  r = {4'd14, 4'd4, 1'b1};
            6'd10: r = {4'd15, 4'd3, 1'b0};
            6'd12: r = {4'd9, 4'd5, 1'b1};
            6'd13: r = {4'd10, 4'd4, 1'b0};
            6'd14: r = {4'd11, 4'd3, 1'b1};
            6'd16: r = {4'd4, 4'd11, 1'b1};
            6'd17: r = {4'd6, 4'd8, 1'b0};
            6'd18: r = {4'd7, 4'd7, 1'b1};
            6'd20: r = {4'd0, 4'd11, 1'b0};
            6'd21: r = {4'd2, 4'd8, 1'b1};
            6'd22: r = {4'd3, 4'd7, 1'b0};
            6'd24: r = {4'd12, 4'd5, 1'b1};
            6'd25: r = {4'd14, 4'd2, 1'b0};
            6'd26: r = {4'd15, 4'd1, 1'b1};
            6'd28: r = {4'd8, 4'd5, 1'b0};
            6'd29: r = {4'd10, 4'd2, 1'b1};
            6'd30: r = {4'd11, 4'd1, 1'b0};
            6'd32: r = {4'd4, 4'd10, 1'b0};
            6'd33: r = {4'd5, 4'd8, 1'b1};
            6'd34: r = {4'd7, 4'd6, 1'b0};
            6'd36: r = {4'd0, 4'd10, 1'b1};
            6'd37: r = {4'd1, 4'd8, 1'b0};
            6'd38: r = {4'd3, 4'd6, 1'b1};
            6'd40: r = {4'd12, 4'd4, 1'b0};
            6'd41: r = {4'd13, 4'd2, 1'b1};
            6'd42: r = {4'd15, 4'd0, 1'b0};
            6'd44: r = {4'd8, 4'd4, 1'b1};
            6'd45: r = {4'd9, 4'd2, 1'b0};
            6'd46: r = {4'd11, 4'd0, 1'b1};
            6'd48: r = {4'd4, 4'd9, 1'b1};
            6'd49: r = {4'd5, 4'd7, 1'b0};
            6'd50: r = {4'd6, 4'd6, 1'b1};
            6'd52: r = {4'd0, 4'd9, 1'b0};
            6'd53: r = {4'd1, 4'd7, 1'b1};
            6'd54: r = {4'd2, 4'd6, 1'b0};
            6'd56: r = {4'd12, 4'd3, 1'b1};
            6'd57: r = {4'd13, 4'd1, 1'b0};
            6'd58: r = {4'd14, 4'd0, 1'b1};
            6'd60: r = {4'd8, 4'd3, 1'b0};
            6'd61: r = {4'd9, 4'd1, 1'b1};
            6'd62: r = {4'd10, 4'd0, 1'b0};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/matrix4_inverse.sv]
// matrix4_inverse: 4x4 fixed-point matrix inverse by the adjugate; uses m4i_pkg and m4i_div.
// After the 16th element is loaded, the shared multiply-accumulate unit forms the minors, the
//   adjugate and the determinant, each 32-bit chunk product in operand, multiply and accumulate
//   phases; then 16 bit-serial divisions follow, or 16 zero results if singular.
// Elements load one per start, only while not busy. One result per strobe cycle; the receiver
//   cannot stall. Reset clears the sequencer, load count and strobe.
`default_nettype none

module matrix4_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] elem_value,
    output logic             busy,
    output logic             valid,
    output logic [31:0]      inv_value,
    output logic             singular_flag,
    output logic             last_flag
);

    localparam int W      = ELEM_WIDTH;
    localparam int MIN_W  = 2 * W + 1;                 // 2x2 minor
    localparam int NCH_M  = (MIN_W + 31) / 32;
    localparam int MST_W  = NCH_M * 32;
    localparam int ADJ_W  = 3 * W + 3;                 // adjugate entry
    localparam int NCH_A  = (ADJ_W + 31) / 32;
    localparam int AST_W  = NCH_A * 32;
    localparam int ACC_W  = 4 * W + 6;                 // determinant and sums
    localparam int PROD_W = W + m4i_pkg::CHUNK_W + 1;
    localparam int CK_W   = $clog2(NCH_A);
    localparam int OP_W   = m4i_pkg::CHUNK_W + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MIN   = 3'd1;
    localparam logic [2:0] S_ADJ   = 3'd2;
    localparam logic [2:0] S_DET   = 3'd3;
    localparam logic [2:0] S_DABS  = 3'd4;
    localparam logic [2:0] S_DIVLD = 3'd5;
    localparam logic [2:0] S_DIVWT = 3'd6;
    localparam logic [2:0] S_SING  = 3'd7;

    // MAC phases: latch operand, multiply, accumulate
    localparam logic [1:0] P_OPND = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_ACC  = 2'd2;

    logic [W-1:0]            mat_reg   [16];
    logic [MST_W-1:0]        minor_reg [12];
    logic [AST_W-1:0]        adj_reg   [16];

    logic [2:0]              state_reg, state_next;
    logic [1:0]              ph_reg, ph_next;
    logic [3:0]              item_reg, item_next;
    logic [1:0]              term_reg, term_next;
    logic [CK_W-1:0]         ck_reg, ck_next;
    logic [3:0]              load_reg, load_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [OP_W-1:0]  opnd_reg, opnd_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]        dabs_reg, dabs_next;
    logic                    dneg_reg, dneg_next;
    logic                    valid_reg, valid_next;
    logic [31:0]             inv_reg, inv_next;
    logic                    sing_reg, sing_next;
    logic                    last_reg, last_next;

    logic [7:0]              mpair;
    logic [8:0]              aterm;
    logic [3:0]              e_addr;
    logic [3:0]              m_addr;
    logic [3:0]              a_addr;
    logic [W-1:0]            elem_rd;
    logic [MST_W-1:0]        min_rd;
    logic [AST_W-1:0]        adj_rd;
    logic [MST_W-1:0]        min_sh;
    logic [AST_W-1:0]        adj_sh;
    logic [OP_W-1:0]         chunk_m;
    logic [OP_W-1:0]         chunk_a;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] prod_shl;
    logic signed [ACC_W-1:0] acc_sum;
    logic                    term_neg;
    logic                    last_ck;
    logic                    load_go;
    logic                    min_we;
    logic                    adj_we;
    m4i_pkg::div_ctl_t       div_ctl;
    logic                    div_done;
    logic [W-1:0]            div_quo;

    // ---- operand selection from the constant tables ----
    assign mpair = m4i_pkg::minor_pair(item_reg, term_reg[0]);
    assign aterm = m4i_pkg::adj_term(item_reg, term_reg);

    always_comb
    begin
        e_addr   = aterm[8:5];
        term_neg = 1'b0;
        case (state_reg)
            S_MIN:
            begin
                // operand element first, multiplicand element in the multiply phase
                e_addr   = (ph_reg == P_OPND) ? mpair[3:0] : mpair[7:4];
                term_neg = term_reg[0];
            end
            S_ADJ:
            begin
                e_addr   = aterm[8:5];
                term_neg = aterm[0];
            end
            S_DET:
            begin
                e_addr   = item_reg;
                term_neg = 1'b0;
            end
            default:
            begin
                e_addr   = aterm[8:5];
                term_neg = 1'b0;
            end
        endcase
    end

    assign m_addr = aterm[4:1];
    assign a_addr = (state_reg == S_DET) ? {item_reg[1:0], 2'b00} : item_reg;

    assign elem_rd = mat_reg[e_addr];
    assign min_rd  = minor_reg[m_addr];
    assign adj_rd  = adj_reg[a_addr];

    // 32-bit chunks of a wide value: low chunks unsigned, top chunk signed
    assign min_sh  = min_rd >> {ck_reg, 5'b0};
    assign adj_sh  = adj_rd >> {ck_reg, 5'b0};
    assign chunk_m = {(ck_reg == CK_W'(NCH_M - 1)) ? min_rd[MST_W-1] : 1'b0, min_sh[31:0]};
    assign chunk_a = {(ck_reg == CK_W'(NCH_A - 1)) ? adj_rd[AST_W-1] : 1'b0, adj_sh[31:0]};

    assign prod_ext = ACC_W'(prod_reg);
    assign prod_shl = prod_ext <<< {ck_reg, 5'b0};
    assign acc_sum  = term_neg ? (acc_reg - prod_shl) : (acc_reg + prod_shl);

    always_comb
    begin
        case (state_reg)
            S_ADJ:   last_ck = (ck_reg == CK_W'(NCH_M - 1));
            S_DET:   last_ck = (ck_reg == CK_W'(NCH_A - 1));
            default: last_ck = 1'b1;
        endcase
    end

    assign load_go = start && !busy;

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        item_next  = item_reg;
        term_next  = term_reg;
        ck_next    = ck_reg;
        load_next  = load_reg;
        acc_next   = acc_reg;
        opnd_next  = opnd_reg;
        prod_next  = prod_reg;
        dabs_next  = dabs_reg;
        dneg_next  = dneg_reg;
        valid_next = 1'b0;
        inv_next   = inv_reg;
        sing_next  = sing_reg;
        last_next  = last_reg;
        min_we     = 1'b0;
        adj_we     = 1'b0;
        div_ctl    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (load_go)
                begin
                    load_next = load_reg + 1'b1;
                    if (load_reg == 4'd15)
                    begin
                        state_next = S_MIN;
                        ph_next    = P_OPND;
                        item_next  = '0;
                        term_next  = '0;
                        ck_next    = '0;
                        acc_next   = '0;
                    end
                end
            end
            S_MIN, S_ADJ, S_DET:
            begin
                case (ph_reg)
                    P_OPND:
                    begin
                        case (state_reg)
                            S_MIN:   opnd_next = OP_W'($signed(elem_rd));
                            S_ADJ:   opnd_next = chunk_m;
                            default: opnd_next = chunk_a;
                        endcase
                        ph_next = P_MUL;
                    end
                    P_MUL:
                    begin
                        prod_next = $signed(elem_rd) * opnd_reg;
                        ph_next   = P_ACC;
                    end
                    default:
                    begin
                        ph_next  = P_OPND;
                        acc_next = acc_sum;
                        ck_next  = last_ck ? '0 : ck_reg + 1'b1;
                        if (last_ck)
                        begin
                            case (state_reg)
                                S_MIN:
                                begin
                                    if (term_reg == 2'd1)
                                    begin
                                        min_we    = 1'b1;
                                        acc_next  = '0;
                                        term_next = '0;
                                        item_next = item_reg + 1'b1;
                                        if (item_reg == 4'd11)
                                        begin
                                            state_next = S_ADJ;
                                            item_next  = '0;
                                        end
                                    end
                                    else
                                        term_next = term_reg + 1'b1;
                                end
                                S_ADJ:
                                begin
                                    if (term_reg == 2'd2)
                                    begin
                                        adj_we    = 1'b1;
                                        acc_next  = '0;
                                        term_next = '0;
                                        item_next = item_reg + 1'b1;
                                        if (item_reg == 4'd15)
                                        begin
                                            state_next = S_DET;
                                            item_next  = '0;
                                        end
                                    end
                                    else
                                        term_next = term_reg + 1'b1;
                                end
                                default:
                                begin
                                    // determinant: row 0 against first adjugate column
                                    item_next = item_reg + 1'b1;
                                    if (item_reg == 4'd3)
                                    begin
                                        state_next = S_DABS;
                                        item_next  = '0;
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_DABS:
            begin
                dneg_next = acc_reg[ACC_W-1];
                dabs_next = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
                item_next = '0;
                state_next = (acc_reg == '0) ? S_SING : S_DIVLD;
            end
            S_DIVLD:
            begin
                div_ctl.start = 1'b1;
                div_ctl.neg   = adj_rd[AST_W-1] ^ dneg_reg;
                state_next    = S_DIVWT;
            end
            S_DIVWT:
            begin
                if (div_done)
                begin
                    valid_next = 1'b1;
                    inv_next   = 32'($signed(div_quo));
                    sing_next  = 1'b0;
                    last_next  = (item_reg == 4'd15);
                    item_next  = item_reg + 1'b1;
                    state_next = (item_reg == 4'd15) ? S_IDLE : S_DIVLD;
                end
            end
            default:
            begin
                // singular: sixteen zero results
                valid_next = 1'b1;
                inv_next   = '0;
                sing_next  = 1'b1;
                last_next  = (item_reg == 4'd15);
                item_next  = item_reg + 1'b1;
                if (item_reg == 4'd15)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= P_OPND;
            item_reg  <= '0;
            term_reg  <= '0;
            ck_reg    <= '0;
            load_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            item_reg  <= item_next;
            term_reg  <= term_next;
            ck_reg    <= ck_next;
            load_reg  <= load_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        opnd_reg <= opnd_next;
        prod_reg <= prod_next;
        dabs_reg <= dabs_next;
        dneg_reg <= dneg_next;
        inv_reg  <= inv_next;
        sing_reg <= sing_next;
        last_reg <= last_next;
        if (load_go)
            mat_reg[load_reg] <= elem_value[W-1:0];
        if (min_we)
            minor_reg[item_reg] <= acc_sum[MST_W-1:0];
        if (adj_we)
            adj_reg[item_reg] <= acc_sum[AST_W-1:0];
    end

    // ---- bit-serial divider ----
    m4i_div #(
        .W     (W),
        .F     (FRAC_BITS),
        .NUM_W (AST_W),
        .DEN_W (ACC_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (adj_rd),
        .den   (dabs_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign busy          = (state_reg != S_IDLE);
    assign valid         = valid_reg;
    assign inv_value     = inv_reg;
    assign singular_flag = sing_reg;
    assign last_flag     = last_reg;

endmodule

`default_nettype wire

[hdl/m4i_div.sv]
// m4i_div: restoring divider, |num| * 2^(2*F) / den, one quotient bit a cycle,
// signed and saturated to W bits.
// Depends on m4i_pkg (div_ctl_t).
`default_nettype none

module m4i_div #(
    parameter int W     = 32,
    parameter int F     = 16,
    parameter int NUM_W = 128,
    parameter int DEN_W = 134
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire m4i_pkg::div_ctl_t        ctl,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]         den,
    output logic                          done,
    output logic [W-1:0]                  quo
);

    localparam int NF_W  = NUM_W + 2 * F;
    localparam int HI_W  = NF_W - W - 1;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int CNT_W = $clog2(W + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CMP  = 2'd1;
    localparam logic [1:0] D_ITER = 2'd2;
    localparam logic [1:0] D_FIN  = 2'd3;

    logic [1:0]       st_reg, st_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic             neg_reg, neg_next;
    logic             sat_reg, sat_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [W:0]       nlow_reg, nlow_next;
    logic [W:0]       q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W-1:0]     quo_reg, quo_next;

    logic [NF_W-1:0]  nfull;
    logic [HI_W-1:0]  hi;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [W:0]       lim;

    assign nfull = {n_reg, {(2 * F){1'b0}}};
    assign hi    = nfull[NF_W-1:W+1];
    assign trial = {rem_reg, nlow_reg[W]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});
    assign lim   = (W + 1)'(1) << (W - 1);

    always_comb
    begin
        st_next   = st_reg;
        n_next    = n_reg;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        rem_next  = rem_reg;
        nlow_next = nlow_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        case (st_reg)
            D_IDLE:
            begin
                if (ctl.start)
                begin
                    n_next   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    neg_next = ctl.neg;
                    st_next  = D_CMP;
                end
            end
            D_CMP:
            begin
                // quotient would need more than W+1 bits
                sat_next  = (CMP_W'(hi) >= CMP_W'(den));
                rem_next  = DEN_W'(hi);
                nlow_next = nfull[W:0];
                q_next    = '0;
                cnt_next  = '0;
                st_next   = D_ITER;
            end
            D_ITER:
            begin
                rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                q_next    = {q_reg[W-1:0], ge};
                nlow_next = {nlow_reg[W-1:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W))
                    st_next = D_FIN;
            end
            D_FIN:
            begin
                if (neg_reg)
                begin
                    if (sat_reg || (q_reg > lim))
                        quo_next = lim[W-1:0];
                    else
                        quo_next = W'(-q_reg);
                end
                else
                begin
                    if (sat_reg || (q_reg > (lim - 1'b1)))
                        quo_next = {1'b0, {(W - 1){1'b1}}};
                    else
                        quo_next = q_reg[W-1:0];
                end
                done_next = 1'b1;
                st_next   = D_IDLE;
            end
            default:
            begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        nlow_reg <= nlow_next;
        q_reg    <= q_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

[hdl/m4i_check.sv]
// m4i_check: port-level assertions for matrix4_inverse, bound to the top level.
// No package dependencies.
`default_nettype none

module m4i_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        valid,
    input wire logic [31:0] inv_value,
    input wire logic        singular_flag,
    input wire logic        last_flag
);

    // results other than the final one come while the block is busy
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_flag |-> busy)
        else $error("result transfer while idle");

    // singular results carry zero
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && singular_flag |-> inv_value == 32'd0)
        else $error("singular result not zero");

    // busy drops only with the final result
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> valid && last_flag)
        else $error("busy fell without final result");

    // nothing follows the final result directly
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_flag |=> !valid)
        else $error("result after final one");

    // divided results are spaced by the divider's iterations, so none directly follows another result
    a_div_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !singular_flag |-> !$past(valid))
        else $error("back-to-back non-singular results");

endmodule

bind matrix4_inverse m4i_check u_m4i_check (.*);

`default_nettype wire
